### rtl/core/sacs_pkg.sv
package sacs_pkg;

  // widths fixed by the item formats
  localparam int unsigned SymW = 5;
  localparam int unsigned OutW = 13;

  typedef struct packed {
    logic            operation;
    logic            first;
    logic [SymW-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [OutW-1:0] match_length;
    logic [OutW-1:0] best_length;
    logic [OutW-1:0] ref_length;
    logic            full_res;
  } out_t;

  // operation codes of an input item
  localparam logic OpAppend = 1'b0;
  localparam logic OpMatch  = 1'b1;

  // datapath actions, one per cycle
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_LOAD,
    ACT_SETOVF,
    ACT_NEWNODE,
    ACT_RDP,
    ACT_RDQ,
    ACT_CAPQ,
    ACT_SETT,
    ACT_LINKNPQ,
    ACT_CLONE,
    ACT_LINKQ,
    ACT_LINKNPNQ,
    ACT_REDIR,
    ACT_MBEGIN,
    ACT_MHIT,
    ACT_MMISS,
    ACT_MFALL,
    ACT_OUT
  } act_e;

  typedef struct packed {
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic sym_ok;
    logic full;
    logic ent_nz;
    logic ent_is_q;
    logic p_zero;
    logic len_solid;
  } st_t;

endpackage

### rtl/core/sacs_if.sv
// input item channel
interface sacs_in_if;
  logic             valid;
  logic             ready;
  sacs_pkg::in_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// result item channel
interface sacs_out_if;
  logic             valid;
  logic             ready;
  sacs_pkg::out_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/sacs_datapath.sv
module sacs_datapath #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sacs_pkg::in_t  in_pl_i,
  input  sacs_pkg::cmd_t cmd_i,
  output sacs_pkg::st_t  st_o,
  output sacs_pkg::out_t out_pl_o
);
  import sacs_pkg::*;

  localparam int unsigned Nodes = 2 * MAX_LEN;
  localparam int unsigned NW    = (Nodes > 1) ? $clog2(Nodes) : 1;
  localparam int unsigned CW    = NW + 1;
  localparam int unsigned LW    = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(ALPHABET);

  typedef logic [ALPHABET-1:0][NW-1:0] row_t;

  // automaton stores: transition rows, suffix links, node lengths
  row_t            row_mem  [Nodes];
  logic [NW-1:0]   link_mem [Nodes];
  logic [LW-1:0]   len_mem  [Nodes];

  row_t            row_rd_q;
  logic [NW-1:0]   link_rd_q;
  logic [LW-1:0]   len_rd_q;

  logic [CW-1:0]   node_cnt_q, node_cnt_d;
  logic [NW-1:0]   last_q, last_d;
  logic [LW-1:0]   ref_len_q, ref_len_d;
  logic [NW-1:0]   match_q, match_d;
  logic [LW-1:0]   cur_q, cur_d;
  logic [LW-1:0]   best_q, best_d;
  logic            ovf_q, ovf_d;
  logic [NW-1:0]   p_q, p_d;
  logic [NW-1:0]   q_q, q_d;
  logic [NW-1:0]   np_q, np_d;
  logic [NW-1:0]   nq_q, nq_d;
  logic [LW-1:0]   lenp_q, lenp_d;
  logic            fb_q, fb_d;
  logic [SymW-1:0] sym_q, sym_d;
  out_t            out_q, out_d;

  logic            row_we, link_we, len_we, rd_en;
  logic [NW-1:0]   row_wa, link_wa, len_wa, rd_addr;
  row_t            row_wd;
  logic [NW-1:0]   link_wd;
  logic [LW-1:0]   len_wd;

  logic [AW-1:0]   sym_idx;
  logic [NW-1:0]   ent;
  logic            sym_ok, stale;
  logic [LW-1:0]   hit_len;

  assign sym_idx = AW'(sym_q);
  assign ent     = row_rd_q[sym_idx];
  assign sym_ok  = 32'(sym_q) < ALPHABET;
  assign stale   = CW'(match_q) >= node_cnt_q;
  assign hit_len = fb_q ? LW'(len_rd_q + LW'(1)) : LW'(cur_q + LW'(1));

  // status towards the controller
  always_comb begin
    st_o.in_op     = in_pl_i.operation;
    st_o.sym_ok    = sym_ok;
    st_o.full      = (32'(ref_len_q) >= MAX_LEN) ||
                     (32'(node_cnt_q) + 32'd2 > Nodes);
    st_o.ent_nz    = ent != '0;
    st_o.ent_is_q  = ent == q_q;
    st_o.p_zero    = p_q == '0;
    st_o.len_solid = len_rd_q == LW'(lenp_q + LW'(1));
  end

  assign out_pl_o = out_q;

  // action decode
  always_comb begin
    node_cnt_d = node_cnt_q;
    last_d     = last_q;
    ref_len_d  = ref_len_q;
    match_d    = match_q;
    cur_d      = cur_q;
    best_d     = best_q;
    ovf_d      = ovf_q;
    p_d        = p_q;
    q_d        = q_q;
    np_d       = np_q;
    nq_d       = nq_q;
    lenp_d     = lenp_q;
    fb_d       = fb_q;
    sym_d      = sym_q;
    out_d      = out_q;
    row_we     = 1'b0;
    row_wa     = '0;
    row_wd     = '0;
    link_we    = 1'b0;
    link_wa    = '0;
    link_wd    = '0;
    len_we     = 1'b0;
    len_wa     = '0;
    len_wd     = '0;
    rd_en      = 1'b0;
    rd_addr    = p_q;
    case (cmd_i.act)
      ACT_INIT: begin
        row_we  = 1'b1;
        link_we = 1'b1;
        len_we  = 1'b1;
      end
      ACT_LOAD: begin
        sym_d = in_pl_i.symbol;
        if (in_pl_i.first && in_pl_i.operation == OpAppend) begin
          node_cnt_d = CW'(1);
          last_d     = '0;
          ref_len_d  = '0;
          ovf_d      = 1'b0;
          row_we     = 1'b1;
          link_we    = 1'b1;
          len_we     = 1'b1;
        end
        if (in_pl_i.first && in_pl_i.operation == OpMatch) begin
          match_d = '0;
          cur_d   = '0;
          best_d  = '0;
        end
      end
      ACT_SETOVF: ovf_d = 1'b1;
      ACT_NEWNODE: begin
        np_d       = NW'(node_cnt_q);
        row_we     = 1'b1;
        row_wa     = NW'(node_cnt_q);
        link_we    = 1'b1;
        link_wa    = NW'(node_cnt_q);
        len_we     = 1'b1;
        len_wa     = NW'(node_cnt_q);
        len_wd     = LW'(ref_len_q + LW'(1));
        p_d        = last_q;
        last_d     = NW'(node_cnt_q);
        node_cnt_d = CW'(node_cnt_q + CW'(1));
        ref_len_d  = LW'(ref_len_q + LW'(1));
      end
      ACT_RDP: rd_en = 1'b1;
      ACT_RDQ: begin
        rd_en   = 1'b1;
        rd_addr = q_q;
      end
      ACT_CAPQ: begin
        q_d    = ent;
        lenp_d = len_rd_q;
      end
      ACT_SETT: begin
        row_we          = 1'b1;
        row_wa          = p_q;
        row_wd          = row_rd_q;
        row_wd[sym_idx] = np_q;
        p_d             = link_rd_q;
      end
      ACT_LINKNPQ: begin
        link_we = 1'b1;
        link_wa = np_q;
        link_wd = q_q;
      end
      ACT_CLONE: begin
        nq_d       = NW'(node_cnt_q);
        node_cnt_d = CW'(node_cnt_q + CW'(1));
        row_we     = 1'b1;
        row_wa     = NW'(node_cnt_q);
        row_wd     = row_rd_q;
        link_we    = 1'b1;
        link_wa    = NW'(node_cnt_q);
        link_wd    = link_rd_q;
        len_we     = 1'b1;
        len_wa     = NW'(node_cnt_q);
        len_wd     = LW'(lenp_q + LW'(1));
      end
      ACT_LINKQ: begin
        link_we = 1'b1;
        link_wa = q_q;
        link_wd = nq_q;
      end
      ACT_LINKNPNQ: begin
        link_we = 1'b1;
        link_wa = np_q;
        link_wd = nq_q;
      end
      ACT_REDIR: begin
        row_we          = 1'b1;
        row_wa          = p_q;
        row_wd          = row_rd_q;
        row_wd[sym_idx] = nq_q;
        p_d             = link_rd_q;
      end
      ACT_MBEGIN: begin
        fb_d = 1'b0;
        if (!sym_ok) begin
          match_d = '0;
          cur_d   = '0;
        end else if (stale) begin
          p_d   = '0;
          cur_d = '0;
        end else begin
          p_d = match_q;
        end
      end
      ACT_MHIT: begin
        match_d = ent;
        cur_d   = hit_len;
        if (hit_len > best_q) best_d = hit_len;
      end
      ACT_MMISS: begin
        match_d = '0;
        cur_d   = '0;
      end
      ACT_MFALL: begin
        p_d  = link_rd_q;
        fb_d = 1'b1;
      end
      ACT_OUT: begin
        out_d.match_length = OutW'(cur_q);
        out_d.best_length  = OutW'(best_q);
        out_d.ref_length   = OutW'(ref_len_q);
        out_d.full_res     = ovf_q;
      end
      default: ;
    endcase
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (len_we) len_mem[len_wa] <= len_wd;
    if (rd_en) begin
      row_rd_q  <= row_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
      len_rd_q  <= len_mem[rd_addr];
    end
  end

  // automaton and match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= CW'(1);
      last_q     <= '0;
      ref_len_q  <= '0;
      match_q    <= '0;
      cur_q      <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      node_cnt_q <= node_cnt_d;
      last_q     <= last_d;
      ref_len_q  <= ref_len_d;
      match_q    <= match_d;
      cur_q      <= cur_d;
      best_q     <= best_d;
      ovf_q      <= ovf_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    q_q    <= q_d;
    np_q   <= np_d;
    nq_q   <= nq_d;
    lenp_q <= lenp_d;
    fb_q   <= fb_d;
    sym_q  <= sym_d;
    out_q  <= out_d;
  end

endmodule

### rtl/core/sacs_controller.sv
module sacs_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sacs_pkg::st_t  st_i,
  output sacs_pkg::cmd_t cmd_o
);
  import sacs_pkg::*;

  typedef enum logic [14:0] {
    S_INIT = 15'h0001,
    S_IDLE = 15'h0002,
    S_ACHK = 15'h0004,
    S_WRD  = 15'h0008,
    S_WCHK = 15'h0010,
    S_QRD  = 15'h0020,
    S_QCHK = 15'h0040,
    S_CL2  = 15'h0080,
    S_CL3  = 15'h0100,
    S_RRD  = 15'h0200,
    S_RCHK = 15'h0400,
    S_MST  = 15'h0800,
    S_MRD  = 15'h1000,
    S_MCHK = 15'h2000,
    S_FIN  = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

  // sequencing of append and match steps
  always_comb begin
    state_d   = state_q;
    cmd_o.act = ACT_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.act = ACT_INIT;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_LOAD;
          state_d   = (st_i.in_op == OpMatch) ? S_MST : S_ACHK;
        end
      end
      S_ACHK: begin
        if (!st_i.sym_ok) begin
          state_d = S_FIN;
        end else if (st_i.full) begin
          cmd_o.act = ACT_SETOVF;
          state_d   = S_FIN;
        end else begin
          cmd_o.act = ACT_NEWNODE;
          state_d   = S_WRD;
        end
      end
      S_WRD: begin
        cmd_o.act = ACT_RDP;
        state_d   = S_WCHK;
      end
      S_WCHK: begin
        if (st_i.ent_nz) begin
          cmd_o.act = ACT_CAPQ;
          state_d   = S_QRD;
        end else begin
          cmd_o.act = ACT_SETT;
          state_d   = st_i.p_zero ? S_FIN : S_WRD;
        end
      end
      S_QRD: begin
        cmd_o.act = ACT_RDQ;
        state_d   = S_QCHK;
      end
      S_QCHK: begin
        if (st_i.len_solid) begin
          cmd_o.act = ACT_LINKNPQ;
          state_d   = S_FIN;
        end else begin
          cmd_o.act = ACT_CLONE;
          state_d   = S_CL2;
        end
      end
      S_CL2: begin
        cmd_o.act = ACT_LINKQ;
        state_d   = S_CL3;
      end
      S_CL3: begin
        cmd_o.act = ACT_LINKNPNQ;
        state_d   = S_RRD;
      end
      S_RRD: begin
        cmd_o.act = ACT_RDP;
        state_d   = S_RCHK;
      end
      S_RCHK: begin
        if (st_i.ent_is_q) begin
          cmd_o.act = ACT_REDIR;
          state_d   = st_i.p_zero ? S_FIN : S_RRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MST: begin
        cmd_o.act = ACT_MBEGIN;
        state_d   = st_i.sym_ok ? S_MRD : S_FIN;
      end
      S_MRD: begin
        cmd_o.act = ACT_RDP;
        state_d   = S_MCHK;
      end
      S_MCHK: begin
        if (st_i.ent_nz) begin
          cmd_o.act = ACT_MHIT;
          state_d   = S_FIN;
        end else if (st_i.p_zero) begin
          cmd_o.act = ACT_MMISS;
          state_d   = S_FIN;
        end else begin
          cmd_o.act = ACT_MFALL;
          state_d   = S_MRD;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.act = ACT_OUT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // result register occupancy
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (cmd_o.act == ACT_OUT) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

### rtl/core/suffix_automaton_common_substring.sv
// steps from input transfer to result: a match follows suffix links back until it finds a
//   transition or reaches the root; an append sets transitions along the suffix links and, on
//   meeting an existing one, either links the new node to it or clones it and redirects to the
//   clone; an append dropped or ignored, or a match on a symbol outside the alphabet, ends early
// throughput: one item at a time; a stalled result holds the controller until it is taken
// reset: asynchronous, active low; after reset an init step clears the root row before any transfer
module suffix_automaton_common_substring #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sacs_in_if.sink        in_i,
  sacs_out_if.source     out_o
);
  import sacs_pkg::*;

  cmd_t cmd;
  st_t  st;

  sacs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  sacs_datapath #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_pl_i  (in_i.payload),
    .cmd_i    (cmd),
    .st_o     (st),
    .out_pl_o (out_o.payload)
  );

endmodule

### rtl/core/sacs_checker.sv
module sacs_checker #(
  parameter int unsigned MAX_LEN = 4096
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input sacs_pkg::out_t out_payload_i
);
  import sacs_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // one item at a time: busy after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // best length never below the current match
  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.best_length >= out_payload_i.match_length)
    else $error("best length below match length");

  // reference length stays within capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_payload_i.ref_length) <= MAX_LEN)
    else $error("reference length beyond capacity");

endmodule

bind suffix_automaton_common_substring sacs_checker #(
  .MAX_LEN (MAX_LEN)
) u_sacs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sacs_pkg::*;

  localparam int unsigned RefCap  = 4096;
  localparam int unsigned Letters = 26;
  localparam int unsigned Nodes   = 2 * RefCap;
  localparam int unsigned RandomItems = 1300;

  // result store, oldest expectation first
  class match_scoreboard;
    out_t pending[$];
    int   errors;
    int   results;

    function void note_item(out_t want);
      pending.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      results++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.match_length !== want.match_length) begin
        $error("match_length: expected %0d, got %0d", want.match_length, got.match_length);
        errors++;
      end
      if (got.best_length !== want.best_length) begin
        $error("best_length: expected %0d, got %0d", want.best_length, got.best_length);
        errors++;
      end
      if (got.ref_length !== want.ref_length) begin
        $error("ref_length: expected %0d, got %0d", want.ref_length, got.ref_length);
        errors++;
      end
      if (got.full_res !== want.full_res) begin
        $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sacs_in_if  in_ch ();
  sacs_out_if out_ch ();

  suffix_automaton_common_substring DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  match_scoreboard sb = new();

  // automaton mirror
  logic [12:0] edge_q [Nodes*Letters];
  int unsigned link_q [Nodes];
  int unsigned depth_q [Nodes];
  int unsigned used_nodes, tail_node, cursor_node, run_len, best_len;
  bit          dropped;
  int          sent_items, appends, queries, clears;

  function automatic void clear_graph();
    for (int a = 0; a < Letters; a++) edge_q[a] = '0;
    link_q[0]  = 0;
    depth_q[0] = 0;
    used_nodes = 1;
    tail_node  = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void grow_graph(int unsigned x);
    int unsigned p, np, q, nq;
    if (depth_q[tail_node] >= RefCap || used_nodes + 2 > Nodes) begin
      dropped = 1'b1;
      return;
    end
    np = used_nodes++;
    for (int a = 0; a < Letters; a++) edge_q[np*Letters+a] = '0;
    depth_q[np] = depth_q[tail_node] + 1;
    link_q[np]  = 0;
    p = tail_node;
    tail_node = np;
    forever begin
      if (edge_q[p*Letters+x] != 0) break;
      edge_q[p*Letters+x] = 13'(np);
      if (p == 0) return;
      p = link_q[p];
    end
    q = edge_q[p*Letters+x];
    if (depth_q[q] == depth_q[p] + 1) begin
      link_q[np] = q;
      return;
    end
    // split q into a clone of the right length
    nq = used_nodes++;
    for (int a = 0; a < Letters; a++) edge_q[nq*Letters+a] = edge_q[q*Letters+a];
    link_q[nq]  = link_q[q];
    depth_q[nq] = depth_q[p] + 1;
    link_q[q]   = nq;
    link_q[np]  = nq;
    forever begin
      if (edge_q[p*Letters+x] != q) break;
      edge_q[p*Letters+x] = 13'(nq);
      if (p == 0) break;
      p = link_q[p];
    end
  endfunction

  function automatic void follow_query(int unsigned x, bit ok);
    int unsigned m;
    m = cursor_node;
    if (m >= used_nodes) begin
      m = 0;
      run_len = 0;
    end
    if (!ok) begin
      m = 0;
      run_len = 0;
    end else if (edge_q[m*Letters+x] != 0) begin
      m = edge_q[m*Letters+x];
      run_len++;
    end else begin
      forever begin
        if (edge_q[m*Letters+x] != 0) begin
          run_len = depth_q[m] + 1;
          m = edge_q[m*Letters+x];
          break;
        end
        if (m == 0) begin
          run_len = 0;
          break;
        end
        m = link_q[m];
      end
    end
    cursor_node = m;
    if (run_len > best_len) best_len = run_len;
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    bit ok;
    ok = it.symbol < Letters;
    if (it.operation == OpAppend) begin
      appends++;
      if (it.first) begin
        clear_graph();
        clears++;
      end
      if (ok) grow_graph(it.symbol);
    end else begin
      queries++;
      if (it.first) begin
        cursor_node = 0;
        run_len = 0;
        best_len = 0;
      end
      follow_query(it.symbol, ok);
    end
    r.match_length = run_len[12:0];
    r.best_length  = best_len[12:0];
    r.ref_length   = depth_q[tail_node][12:0];
    r.full_res     = dropped;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  bit no_gaps;

  // one input transfer
  task automatic send_item(bit op, bit first, logic [4:0] sym);
    in_t it;
    int unsigned gap;
    it.operation = op;
    it.first     = first;
    it.symbol    = sym;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(predict_result(it));
    sent_items++;
  endtask

  function automatic logic [4:0] pick_symbol(int unsigned k);
    if ($urandom_range(0, 49) == 0) return 5'($urandom_range(Letters, 31));
    return 5'($urandom_range(0, k - 1));
  endfunction

  // reference string followed by a few query runs
  task automatic random_session();
    int unsigned k, n;
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(2, Letters) : $urandom_range(2, 4);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
    for (int i = 0; i < n; i++)
      send_item(OpAppend, i == 0 || $urandom_range(0, 99) == 0, pick_symbol(k));
    repeat ($urandom_range(1, 3)) begin
      n = $urandom_range(3, 30);
      for (int i = 0; i < n; i++)
        send_item(OpMatch, i == 0 ? $urandom_range(0, 3) != 0 : $urandom_range(0, 49) == 0,
                  pick_symbol(k));
    end
  endtask

  // result side with random stalls
  initial begin
    int unsigned hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        out_ch.ready <= (hold == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    no_gaps = 1'b0;
    for (int i = 0; i < Nodes*Letters; i++) edge_q[i] = '0;
    clear_graph();
    cursor_node = 0;
    run_len = 0;
    best_len = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes of the symbol field, invalid symbols, clears and a stale cursor
    send_item(OpMatch, 1'b0, 5'd0);
    send_item(OpAppend, 1'b1, 5'd0);
    send_item(OpAppend, 1'b0, 5'd1);
    send_item(OpAppend, 1'b0, 5'd0);
    send_item(OpAppend, 1'b0, 5'd1);
    send_item(OpAppend, 1'b0, 5'd25);
    send_item(OpAppend, 1'b0, 5'd31);
    send_item(OpAppend, 1'b0, 5'd16);
    send_item(OpMatch, 1'b1, 5'd0);
    send_item(OpMatch, 1'b0, 5'd1);
    send_item(OpMatch, 1'b0, 5'd0);
    send_item(OpMatch, 1'b0, 5'd1);
    send_item(OpMatch, 1'b0, 5'd25);
    send_item(OpMatch, 1'b0, 5'd16);
    send_item(OpMatch, 1'b0, 5'd0);
    send_item(OpMatch, 1'b0, 5'd26);
    send_item(OpMatch, 1'b0, 5'd1);
    send_item(OpAppend, 1'b1, 5'd31);
    send_item(OpMatch, 1'b0, 5'd0);
    send_item(OpAppend, 1'b1, 5'd2);
    send_item(OpMatch, 1'b0, 5'd2);
    send_item(OpMatch, 1'b1, 5'd2);

    // a repeated symbol run, then a query over it
    send_item(OpAppend, 1'b1, 5'd0);
    for (int i = 0; i < 40; i++) send_item(OpAppend, 1'b0, 5'd0);
    send_item(OpAppend, 1'b0, 5'd1);
    send_item(OpMatch, 1'b1, 5'd0);
    send_item(OpMatch, 1'b0, 5'd0);
    send_item(OpAppend, 1'b1, 5'd3);

    // random sessions
    while (sent_items < RandomItems) random_session();

    @(posedge clk_i);
    in_ch.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d transfers: %0d appends (%0d clears), %0d queries",
             sent_items, appends, clears, queries);
    $display("directed symbol extremes and random sessions, %0d results checked",
             sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### suffix_automaton_common_substring.f
rtl/core/sacs_pkg.sv
rtl/core/sacs_if.sv
rtl/core/sacs_datapath.sv
rtl/core/sacs_controller.sv
rtl/core/suffix_automaton_common_substring.sv
rtl/core/sacs_checker.sv
sim/testbench.sv
